/* src/pfsb_pkg.sv */
// Package for the page framebuffer sprite blitter.
// Holds store sizing, operation codes and the controller/datapath structs.
// No dependencies.
package pfsb_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;

    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    typedef enum logic [1:0] {
        OP_DRAW   = 2'd0,
        OP_CLIP   = 2'd1,
        OP_MASKED = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch decoded transaction
        logic clear;   // write zero at clear pointer
        logic wb0;     // modify/write first page byte, read second
        logic wb1;     // modify/write second page byte
        logic finish;  // load result register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic is_read;
        logic out_free;
    } t_dp_status;

endpackage

/* src/pfsb_if.sv */
// Handshake interfaces for the blitter input and result channels.
// Depends on nothing; field widths are fixed by the transaction format.
interface pfsb_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [7:0]        pattern_byte;
    logic [7:0]        mask_byte;
    logic signed [7:0] sprite_x;
    logic signed [7:0] sprite_y;
    logic [7:0]        sprite_width;
    logic [7:0]        column_index;
    logic              mirror;
    logic [9:0]        read_address;

    modport source (
        output valid, operation, pattern_byte, mask_byte, sprite_x, sprite_y,
               sprite_width, column_index, mirror, read_address,
        input  ready
    );
    modport sink (
        input  valid, operation, pattern_byte, mask_byte, sprite_x, sprite_y,
               sprite_width, column_index, mirror, read_address,
        output ready
    );
endinterface

interface pfsb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       on_screen;

    modport source (output valid, read_data, on_screen, input ready);
    modport sink   (input valid, read_data, on_screen, output ready);
endinterface

/* src/pfsb_ctrl.sv */
// Sequencing state machine for the blitter.
// Depends on pfsb_pkg (command/status structs).
module pfsb_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  pfsb_pkg::t_dp_status  i_status,
    output logic                  o_in_ready,
    output pfsb_pkg::t_dp_cmd     o_cmd
);
    import pfsb_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD0,
        S_WB0,
        S_WB1,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_RD0;
                end
            end
            S_RD0: begin
                n_state = S_WB0;
            end
            S_WB0: begin
                o_cmd.wb0 = 1'b1;
                n_state   = i_status.is_read ? S_DONE : S_WB1;
            end
            S_WB1: begin
                o_cmd.wb1 = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                o_cmd.finish = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* src/pfsb_datapath.sv */
// Datapath: placement/clip decode, frame store, read-modify-write, result register.
// Depends on pfsb_pkg and the pfsb_in_if / pfsb_out_if interfaces.
module pfsb_datapath #(
    parameter int SCREEN_WIDTH  = pfsb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = pfsb_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ready,
    pfsb_in_if.sink               i_in,
    pfsb_out_if.source            o_out,
    input  pfsb_pkg::t_dp_cmd     i_cmd,
    output pfsb_pkg::t_dp_status  o_status
);
    import pfsb_pkg::*;

    localparam logic signed [10:0] LP_W   = 11'(SCREEN_WIDTH);
    localparam logic signed [10:0] LP_H   = 11'(SCREEN_HEIGHT);
    localparam logic [19:0]        LP_W20 = 20'(SCREEN_WIDTH);

    assign i_in.ready = i_ready;

    // ---- decode of the incoming transaction ----
    logic signed [10:0] x_ext, y_ext, w_ext, idx_ext, col, base0, base1;
    logic               hit, valid0, valid1;
    logic [7:0]         pat_eff, mask0, mask1;
    logic [15:0]        wide;
    logic [4:0]         pg0, pg1;
    logic [19:0]        addr0_full, addr1_full;

    always_comb begin
        x_ext   = {{3{i_in.sprite_x[7]}}, i_in.sprite_x};
        y_ext   = {{3{i_in.sprite_y[7]}}, i_in.sprite_y};
        w_ext   = {3'b000, i_in.sprite_width};
        idx_ext = {3'b000, i_in.column_index};
        col     = i_in.mirror ? (x_ext + w_ext - 11'sd1 - idx_ext) : (x_ext + idx_ext);
        hit     = (i_in.column_index < i_in.sprite_width)
                  && (col >= 11'sd0) && (col < LP_W)
                  && (y_ext > -11'sd8) && (y_ext < LP_H);

        pat_eff = (i_in.operation == OP_MASKED) ? (i_in.pattern_byte & i_in.mask_byte)
                                                : i_in.pattern_byte;
        wide    = 16'(pat_eff) << i_in.sprite_y[2:0];

        base0 = {y_ext[10:3], 3'b000};
        base1 = base0 + 11'sd8;
        for (int k = 0; k < 8; k++) begin
            mask0[k] = (base0 + 11'(k)) < LP_H;
            mask1[k] = (base1 + 11'(k)) < LP_H;
        end
        // page above the top edge writes nothing
        valid0 = !y_ext[10];
        valid1 = (i_in.sprite_y[2:0] != 3'd0) && (base1 < LP_H);

        pg0 = y_ext[7:3];
        pg1 = 5'(y_ext[7:3] + 5'd1);
        addr0_full = {15'b0, pg0} * LP_W20 + {11'b0, col[8:0]};
        addr1_full = {15'b0, pg1} * LP_W20 + {11'b0, col[8:0]};
    end

    // ---- latched transaction ----
    logic [ADDR_W-1:0] r_addr0, r_addr1;
    logic [7:0]        r_bits0, r_bits1;
    logic              r_we0, r_we1, r_clip, r_is_read, r_touch;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_read <= (i_in.operation == OP_READ);
            r_clip    <= (i_in.operation == OP_CLIP);
            r_touch   <= (i_in.operation != OP_READ) && hit;
            r_we0     <= (i_in.operation != OP_READ) && hit && valid0;
            r_we1     <= (i_in.operation != OP_READ) && hit && valid1;
            r_addr0   <= (i_in.operation == OP_READ) ? i_in.read_address
                                                     : addr0_full[ADDR_W-1:0];
            r_addr1   <= addr1_full[ADDR_W-1:0];
            r_bits0   <= wide[7:0] & mask0;
            r_bits1   <= wide[15:8] & mask1;
        end
    end

    // ---- frame store, one write and one registered read per cycle ----
    logic [7:0]        r_mem [STORE_DEPTH];
    logic [7:0]        r_rdata, r_read_hold, mod_byte;
    logic [ADDR_W-1:0] r_clr_addr, mem_raddr, mem_waddr;
    logic              mem_we;
    logic [7:0]        mem_wdata;

    always_comb begin
        mod_byte  = r_clip ? (r_rdata & ~(i_cmd.wb1 ? r_bits1 : r_bits0))
                           : (r_rdata |  (i_cmd.wb1 ? r_bits1 : r_bits0));
        mem_raddr = i_cmd.wb0 ? r_addr1 : r_addr0;
        mem_we    = i_cmd.clear || (i_cmd.wb0 && r_we0) || (i_cmd.wb1 && r_we1);
        mem_waddr = i_cmd.clear ? r_clr_addr : (i_cmd.wb1 ? r_addr1 : r_addr0);
        mem_wdata = i_cmd.clear ? 8'h00 : mod_byte;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
        if (i_cmd.wb0) begin
            r_read_hold <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // ---- result register ----
    logic       r_out_valid, r_out_on;
    logic [7:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_data <= r_is_read ? r_read_hold : 8'h00;
            r_out_on   <= r_touch;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.read_data = r_out_data;
    assign o_out.on_screen = r_out_on;

    assign o_status.clear_last = (r_clr_addr == {ADDR_W{1'b1}});
    assign o_status.is_read    = r_is_read;
    assign o_status.out_free   = !r_out_valid || o_out.ready;

endmodule

/* src/page_framebuffer_sprite_blit.sv */
// Top level of the 1-bit page-mode framebuffer sprite column blitter.
// Depends on pfsb_pkg, pfsb_if, pfsb_ctrl and pfsb_datapath.
//
// Usage:
//   i_in  carries one transaction per sprite column (or one byte read):
//         operation, pattern/mask, sprite position, width, column index,
//         mirror flag and read address. Accepted when valid && ready.
//   o_out returns exactly one transaction per input: read_data (stored byte
//         for a read, zero otherwise) and on_screen (column touched memory).
// Sequence: a draw, clip or masked draw steps through accept, read first byte, write
//   first byte while reading second, write second byte, result; the next transaction is
//   taken only after the result register has loaded. A read skips the second write.
//   The frame store's separate read and write ports let the first write overlap the
//   second read.
// Reset: i_rst_n (synchronous, active low) starts a clearing pass that zeroes
//   the 1024-byte frame store, one byte per cycle; i_in.ready
//   stays low during it.
// Back-pressure: the result register holds a finished transaction while
//   o_out.ready is low; the next input is still accepted and processed, and
//   only its result load waits for the register to free up.
module page_framebuffer_sprite_blit #(
    parameter int SCREEN_WIDTH  = pfsb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = pfsb_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pfsb_in_if.sink     i_in,
    pfsb_out_if.source  o_out
);
    import pfsb_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    // sequencer: clear pass, accept, RMW steps, result hand-off
    pfsb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // decode, frame store and result register
    pfsb_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ready  (w_in_ready),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cmd    (w_cmd),
        .o_status (w_status)
    );

    // no input transaction is taken while the store is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear |-> !(i_in.valid && i_in.ready))
        else $error("input accepted during clearing pass");

    // controller issues at most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("overlapping datapath commands");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> (!o_out.valid || o_out.ready))
        else $error("result register overwritten");

    // every result load shows up on the output channel next cycle
    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |=> o_out.valid)
        else $error("result load did not raise valid");

endmodule

/* tb/page_framebuffer_sprite_blit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for page_framebuffer_sprite_blit.
// Predicts every result from a shadow copy of the frame store and checks the result channel.
// Depends on pfsb_pkg, pfsb_if and the blitter RTL.
module page_framebuffer_sprite_blit_tb;
    import pfsb_pkg::*;

    localparam int SCR_W      = SCREEN_WIDTH_DEF;
    localparam int SCR_H      = SCREEN_HEIGHT_DEF;
    localparam int RAND_ITEMS = 750;
    localparam int QUIET_TAIL = 120;   // last transactions are sent with no idling
    localparam int HOLD_AT    = 250;   // input count that triggers the long result hold-off
    localparam int HOLD_LEN   = 300;
    localparam int WD_LIMIT   = 5000;  // covers the clearing pass and the hold-off
    localparam int DRAIN      = 20;

    // One sprite column (or byte read) as sent on the input channel.
    typedef struct packed {
        t_op        op;
        logic [7:0] pattern;
        logic [7:0] mask;
        logic [7:0] x;        // signed
        logic [7:0] y;        // signed
        logic [7:0] width;
        logic [7:0] col_idx;
        logic       mirror;
        logic [9:0] raddr;
    } t_blit_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       on_screen;
    } t_blit_result;

    logic i_clk;
    logic i_rst_n;

    pfsb_in_if  blit_in ();
    pfsb_out_if blit_out ();

    page_framebuffer_sprite_blit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (blit_in),
        .o_out   (blit_out)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Stimulus, predicted results and the shadow frame store
    t_blit_item   blit_pending [$];
    t_blit_result fb_expected [$];
    logic [7:0]   shadow_fb [0:STORE_DEPTH-1];

    t_blit_item in_cur;
    logic       in_accepted;
    int         in_gap;
    int         out_gap;
    int         hold_left;
    logic       hold_done;
    logic       rdy_next;
    int         in_count;
    int         out_count;
    int         fail_cnt;
    int         wd_count;
    int         op_count [4];
    int         hit_count;

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    // Merge one page byte into the shadow store; rows past the screen bottom
    // and pages outside the screen are left alone.
    function automatic void merge_page(int page, int col, logic [7:0] bits, t_op op);
        int         left;
        logic [7:0] rowmask;
        int         addr;
        if (page < 0 || page * 8 >= SCR_H)
            return;
        left    = SCR_H - page * 8;
        rowmask = (left >= 8) ? 8'hFF : 8'((1 << left) - 1);
        bits    = bits & rowmask;
        addr    = (page * SCR_W + col) & (STORE_DEPTH - 1);
        if (op == OP_CLIP)
            shadow_fb[addr] = shadow_fb[addr] & ~bits;
        else
            shadow_fb[addr] = shadow_fb[addr] | bits;
    endfunction

    // Expected result of one transaction; updates the shadow store.
    function automatic t_blit_result blit_predict(t_blit_item it);
        t_blit_result r;
        int           xs;
        int           ys;
        int           w;
        int           idx;
        int           col;
        int           s;
        int           page;
        logic [7:0]   pat;
        logic [15:0]  wide;
        r.read_data = 8'h00;
        r.on_screen = 1'b0;
        if (it.op == OP_READ) begin
            r.read_data = shadow_fb[it.raddr];
            return r;
        end
        xs  = $signed(it.x);
        ys  = $signed(it.y);
        w   = it.width;
        idx = it.col_idx;
        // column index past the sprite's width
        if (idx >= w)
            return r;
        col = it.mirror ? xs + (w - 1 - idx) : xs + idx;
        if (col < 0 || col >= SCR_W)
            return r;
        // the whole column lies above or below the screen
        if (ys <= -8 || ys >= SCR_H)
            return r;
        pat = it.pattern;
        if (it.op == OP_MASKED)
            pat = pat & it.mask;
        s    = ys & 7;
        page = (ys - s) / 8;
        wide = {8'h00, pat} << s;
        merge_page(page, col, wide[7:0], it.op);
        if (s != 0)
            merge_page(page + 1, col, wide[15:8], it.op);
        r.on_screen = 1'b1;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus building
    // ---------------------------------------------------------------

    function automatic void queue_item(t_op op, int pat, int msk, int x, int y, int w,
                                       int idx, int mir, int addr);
        t_blit_item it;
        it.op      = op;
        it.pattern = 8'(pat);
        it.mask    = 8'(msk);
        it.x       = 8'(x);
        it.y       = 8'(y);
        it.width   = 8'(w);
        it.col_idx = 8'(idx);
        it.mirror  = 1'(mir);
        it.raddr   = 10'(addr);
        blit_pending.push_back(it);
    endfunction

    function automatic t_op pick_draw_op();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8)
            return OP_DRAW;
        else if (r < 13)
            return OP_CLIP;
        return OP_MASKED;
    endfunction

    // A sprite, column by column (a wide one only in part), then one or two read-backs
    // of bytes near it or, where those are off screen, anywhere in the store.
    function automatic void queue_sprite();
        int  x;
        int  y;
        int  w;
        int  pat;
        int  msk;
        int  mir;
        int  col;
        int  page;
        int  n;
        t_op op;
        op  = pick_draw_op();
        msk = $urandom_range(0, 255);
        mir = $urandom_range(0, 1);
        if ($urandom_range(0, 9) == 0) begin
            // wide sprite at any position: only a few of its columns
            x = $urandom_range(0, 255) - 128;
            y = $urandom_range(0, 79) - 12;
            w = $urandom_range(100, 255);
            for (n = 0; n < 6; n++)
                queue_item(op, $urandom_range(0, 255), msk, x, y, w,
                           $urandom_range(0, 254), mir, 0);
        end else begin
            x = $urandom_range(0, 147) - 12;
            y = $urandom_range(0, 79) - 12;
            w = $urandom_range(1, 12);
            for (n = 0; n < w; n++) begin
                pat = $urandom_range(0, 255);
                queue_item(op, pat, msk, x, y, w, n, mir, 0);
            end
        end
        for (n = $urandom_range(1, 2); n > 0; n--) begin
            col  = x + $urandom_range(0, 11);
            page = (y >>> 3) + $urandom_range(0, 1);
            if (col >= 0 && col < SCR_W && page >= 0 && page < SCR_H / 8)
                queue_item(OP_READ, 0, 0, 0, 0, 1, 0, 0, page * SCR_W + col);
            else
                queue_item(OP_READ, 0, 0, 0, 0, 1, 0, 0, $urandom_range(0, STORE_DEPTH - 1));
        end
    endfunction

    function automatic void queue_noise();
        queue_item(t_op'(2'($urandom_range(0, 3))), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(1, 255), $urandom_range(0, 254), $urandom_range(0, 1),
                   $urandom_range(0, STORE_DEPTH - 1));
    endfunction

    function automatic void queue_directed();
        // fresh store reads zero
        queue_item(OP_READ,   0,     0,     0,    0,    1,   0,   0, 0);
        // full byte at the top-left corner, then partial clear
        queue_item(OP_DRAW,   8'hFF, 0,     0,    0,    1,   0,   0, 0);
        queue_item(OP_READ,   0,     0,     0,    0,    1,   0,   0, 0);
        queue_item(OP_CLIP,   8'h0F, 0,     0,    0,    1,   0,   0, 0);
        queue_item(OP_READ,   0,     0,     0,    0,    1,   0,   0, 0);
        // one row above the screen: first page dropped, rest shifted into page 0
        queue_item(OP_DRAW,   8'hFF, 0,     5,   -1,    1,   0,   0, 0);
        queue_item(OP_READ,   0,     0,     0,    0,    1,   0,   0, 5);
        // fully above and fully below the screen
        queue_item(OP_DRAW,   8'hFF, 0,     6,   -8,    1,   0,   0, 0);
        queue_item(OP_DRAW,   8'hFF, 0,     6,   64,    1,   0,   0, 0);
        // last page, bits below the bottom row dropped; last store byte
        queue_item(OP_DRAW,   8'hFF, 0,   127,   61,    1,   0,   0, 0);
        queue_item(OP_READ,   0,     0,     0,    0,    1,   0,   0, STORE_DEPTH - 1);
        // masked draw straddling pages 0 and 1
        queue_item(OP_MASKED, 8'hAA, 8'hF0, 10,   3,    1,   0,   0, 0);
        queue_item(OP_READ,   0,     0,     0,    0,    1,   0,   0, 10);
        queue_item(OP_READ,   0,     0,     0,    0,    1,   0,   0, SCR_W + 10);
        // clip with bits falling off the top: byte still counts as touched
        queue_item(OP_CLIP,   8'hFF, 0,    10,   -3,    1,   0,   0, 0);
        // column just right of the screen
        queue_item(OP_DRAW,   8'h81, 0,   127,    8,    2,   1,   0, 0);
        // field extremes: far-left sprite, widest width, mirrored both ways
        queue_item(OP_DRAW,   8'h3C, 0,  -128,   20,  255, 254,   0, 0);
        queue_item(OP_DRAW,   8'h3C, 0,  -128,   20,  255, 254,   1, 0);
        queue_item(OP_DRAW,   8'hC3, 0,   120,   -7,    8,   0,   1, 0);
        // column index at the width
        queue_item(OP_DRAW,   8'hFF, 0,    40,   16,    3,   3,   0, 0);
        queue_item(OP_MASKED, 8'hFF, 8'hFF, 127, 127,   1,   0,   1, 0);
        queue_item(OP_CLIP,   8'hFF, 8'hFF, -128, -128, 1,   0,   0, 0);
        queue_item(OP_READ,   0,     0,     0,    0,    1,   0,   0, 3 * SCR_W + 126);
        queue_item(OP_READ,   0,     0,     0,    0,    1,   0,   0, SCR_W * 7 + 127);
        queue_item(OP_READ,   0,     0,     0,    0,    1,   0,   0, 512);
    endfunction

    // Only the tail of the run is sent and taken without idling.
    function automatic logic in_quiet_tail();
        return blit_pending.size() < QUIET_TAIL;
    endfunction

    // ---------------------------------------------------------------
    // Input driver: note acceptance at the rising edge, drive at the falling edge
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && blit_in.valid && blit_in.ready) begin
            fb_expected.push_back(blit_predict(in_cur));
            op_count[in_cur.op] = op_count[in_cur.op] + 1;
            in_count    = in_count + 1;
            in_accepted = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (in_accepted || !blit_in.valid)) begin
            in_accepted = 1'b0;
            if (in_gap > 0) begin
                in_gap = in_gap - 1;
                blit_in.valid <= 1'b0;
            end else if (blit_pending.size() > 0) begin
                if (!in_quiet_tail() && $urandom_range(0, 5) == 0) begin
                    // start an idle burst, this cycle included
                    in_gap = $urandom_range(0, 3);
                    blit_in.valid <= 1'b0;
                end else begin
                    in_cur = blit_pending.pop_front();
                    blit_in.operation    <= in_cur.op;
                    blit_in.pattern_byte <= in_cur.pattern;
                    blit_in.mask_byte    <= in_cur.mask;
                    blit_in.sprite_x     <= in_cur.x;
                    blit_in.sprite_y     <= in_cur.y;
                    blit_in.sprite_width <= in_cur.width;
                    blit_in.column_index <= in_cur.col_idx;
                    blit_in.mirror       <= in_cur.mirror;
                    blit_in.read_address <= in_cur.raddr;
                    blit_in.valid        <= 1'b1;
                end
            end else begin
                blit_in.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor: compare at the rising edge against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_blit_result exp_res;
        if (i_rst_n && blit_out.valid && blit_out.ready) begin
            out_count = out_count + 1;
            if (fb_expected.size() == 0) begin
                $error("result transaction with nothing expected: read_data=%0h on_screen=%0b",
                       blit_out.read_data, blit_out.on_screen);
                fail_cnt = fail_cnt + 1;
            end else begin
                exp_res = fb_expected.pop_front();
                if (blit_out.read_data !== exp_res.read_data) begin
                    $error("read_data mismatch: expected %0h, actual %0h",
                           exp_res.read_data, blit_out.read_data);
                    fail_cnt = fail_cnt + 1;
                end
                if (blit_out.on_screen !== exp_res.on_screen) begin
                    $error("on_screen mismatch: expected %0b, actual %0b",
                           exp_res.on_screen, blit_out.on_screen);
                    fail_cnt = fail_cnt + 1;
                end
                if (exp_res.on_screen)
                    hit_count = hit_count + 1;
            end
        end
    end

    // Result back-pressure: short random stalls plus one long hold-off that
    // lets the blitter fill up and drop its input ready.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                rdy_next  = 1'b0;
            end else if (!hold_done && in_count >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN - 1;
                rdy_next  = 1'b0;
            end else if (out_gap > 0) begin
                out_gap  = out_gap - 1;
                rdy_next = 1'b0;
            end else if (!in_quiet_tail() && $urandom_range(0, 4) == 0) begin
                out_gap  = $urandom_range(0, 3);
                rdy_next = 1'b0;
            end else begin
                rdy_next = 1'b1;
            end
            blit_out.ready <= rdy_next;
        end
    end

    // Watchdog: cycles in a row with no transaction on either channel
    always @(posedge i_clk) begin
        if ((blit_in.valid && blit_in.ready) || (blit_out.valid && blit_out.ready))
            wd_count = 0;
        else
            wd_count = wd_count + 1;
        if (wd_count >= WD_LIMIT) begin
            $display("watchdog: %0d cycles without a transaction, %0d results outstanding",
                     wd_count, fb_expected.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequence: reset, fill the stimulus queue, wait for drain, report
    // ---------------------------------------------------------------
    initial begin
        int base;
        int r;
        // every input known from time zero
        i_rst_n              = 1'b0;
        blit_in.valid        = 1'b0;
        blit_in.operation    = OP_DRAW;
        blit_in.pattern_byte = 8'h00;
        blit_in.mask_byte    = 8'h00;
        blit_in.sprite_x     = 8'h00;
        blit_in.sprite_y     = 8'h00;
        blit_in.sprite_width = 8'h01;
        blit_in.column_index = 8'h00;
        blit_in.mirror       = 1'b0;
        blit_in.read_address = 10'h000;
        blit_out.ready       = 1'b0;
        in_accepted = 1'b0;
        in_gap      = 0;
        out_gap     = 0;
        hold_left   = 0;
        hold_done   = 1'b0;
        in_count    = 0;
        out_count   = 0;
        fail_cnt    = 0;
        wd_count    = 0;
        hit_count   = 0;
        for (int i = 0; i < 4; i++)
            op_count[i] = 0;
        for (int i = 0; i < STORE_DEPTH; i++)
            shadow_fb[i] = 8'h00;

        queue_directed();
        base = blit_pending.size();
        // mostly whole sprites with random content, the rest reads and noise
        while (blit_pending.size() < base + RAND_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r < 6)
                queue_sprite();
            else if (r < 8)
                queue_item(OP_READ, 0, 0, 0, 0, 1, 0, 0, $urandom_range(0, STORE_DEPTH - 1));
            else
                queue_noise();
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (blit_pending.size() > 0 || blit_in.valid || fb_expected.size() > 0)
            @(posedge i_clk);
        // catch any stray result after the last expected one
        repeat (DRAIN) @(posedge i_clk);

        $display("Sent %0d transactions (draw %0d, clip %0d, masked %0d, read %0d).",
                 in_count, op_count[OP_DRAW], op_count[OP_CLIP], op_count[OP_MASKED],
                 op_count[OP_READ]);
        $display("Checked %0d results, %0d columns landed on screen, %0d failures.",
                 out_count, hit_count, fail_cnt);
        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
src/pfsb_pkg.sv
src/pfsb_if.sv
src/pfsb_ctrl.sv
src/pfsb_datapath.sv
src/page_framebuffer_sprite_blit.sv
tb/page_framebuffer_sprite_blit_tb.sv
